>>> design/rgi_pkg.sv
// shared types and constants for the readability grade index unit
package rgi_pkg;

  typedef enum logic [2:0] {
    S_COUNT,
    S_NUM,
    S_MAG,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic count_en;
    logic load_num;
    logic load_mag;
    logic div_step;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_EXCLAIM  = 8'h21;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

  localparam int COEF_L   = 588;
  localparam int COEF_S   = 2960;
  localparam int COEF_W   = 1580;
  localparam int DEN_W    = 100;
  localparam int GRADE_HI = 16;

  localparam int FIELD_W  = 16;
  localparam int GRADE_W  = 5;

endpackage

>>> design/readability_grade_index_unit.sv
// Coleman-Liau readability index over a byte stream: top level
// Characters are taken one per cycle while a text is being counted. After the
// transfer of the byte marked last, the block stops taking input while S_NUM
// forms the numerator, S_MAG adds the rounding bias, and in S_DIV a restoring
// divider produces the quotient one bit per cycle; S_DONE then moves the
// result into the output register, which can then wait for the sink while
// the next text is counted. If the previous result has not yet been taken,
// the hand-off waits for it.
module readability_grade_index_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           ch,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rgi_pkg::GRADE_W-1:0]          grade,
  output logic signed [rgi_pkg::FIELD_W-1:0]   index,
  output logic [rgi_pkg::FIELD_W-1:0]          letters,
  output logic [rgi_pkg::FIELD_W-1:0]          words,
  output logic [rgi_pkg::FIELD_W-1:0]          sentences
);

  rgi_pkg::cmd_t    cmd;
  rgi_pkg::status_t status;

  rgi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  rgi_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ch        (ch),
    .last      (last),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .grade     (grade),
    .index     (index),
    .letters   (letters),
    .words     (words),
    .sentences (sentences)
  );

endmodule

>>> design/rgi_ctrl.sv
// sequencing of counting, index arithmetic, division and result hand-off
module rgi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  input  rgi_pkg::status_t status,
  output logic             in_ready,
  output rgi_pkg::cmd_t    cmd
);

  rgi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgi_pkg::S_COUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rgi_pkg::S_COUNT: begin
        if (in_valid && last) state_next = rgi_pkg::S_NUM;
      end
      rgi_pkg::S_NUM: state_next = rgi_pkg::S_MAG;
      rgi_pkg::S_MAG: state_next = rgi_pkg::S_DIV;
      rgi_pkg::S_DIV: begin
        if (status.div_last) state_next = rgi_pkg::S_DONE;
      end
      rgi_pkg::S_DONE: begin
        if (!status.out_busy) state_next = rgi_pkg::S_COUNT;
      end
      default: state_next = rgi_pkg::S_COUNT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      rgi_pkg::S_COUNT: begin
        in_ready     = 1'b1;
        cmd.count_en = in_valid;
      end
      rgi_pkg::S_NUM: cmd.load_num = 1'b1;
      rgi_pkg::S_MAG: cmd.load_mag = 1'b1;
      rgi_pkg::S_DIV: cmd.div_step = 1'b1;
      rgi_pkg::S_DONE: begin
        cmd.load_out = !status.out_busy;
        cmd.clear    = !status.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/rgi_datapath.sv
// counters, numerator, bit-serial divider and output register
module rgi_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rgi_pkg::cmd_t                        cmd,
  input  logic [7:0]                           ch,
  input  logic                                 last,
  input  logic                                 out_ready,
  output rgi_pkg::status_t                     status,
  output logic                                 out_valid,
  output logic [rgi_pkg::GRADE_W-1:0]          grade,
  output logic signed [rgi_pkg::FIELD_W-1:0]   index,
  output logic [rgi_pkg::FIELD_W-1:0]          letters,
  output logic [rgi_pkg::FIELD_W-1:0]          words,
  output logic [rgi_pkg::FIELD_W-1:0]          sentences
);

  localparam int NUM_W  = COUNT_BITS + 14;
  localparam int MAG_W  = COUNT_BITS + 13;
  localparam int DVD_W  = COUNT_BITS + 15;
  localparam int DVS_W  = COUNT_BITS + 8;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam int CLIP_W = (COUNT_BITS > rgi_pkg::FIELD_W) ? COUNT_BITS : rgi_pkg::FIELD_W;

  localparam logic signed [NUM_W-1:0] CoefL = NUM_W'(rgi_pkg::COEF_L);
  localparam logic signed [NUM_W-1:0] CoefS = NUM_W'(rgi_pkg::COEF_S);
  localparam logic signed [NUM_W-1:0] CoefW = NUM_W'(rgi_pkg::COEF_W);
  localparam logic [DVS_W-1:0]        DenK  = DVS_W'(rgi_pkg::DEN_W);
  localparam logic [DVS_W-1:0]        DvsK  = DVS_W'(2 * rgi_pkg::DEN_W);
  localparam logic [CNT_W-1:0]        DivLast = CNT_W'(DVD_W - 1);

  logic [COUNT_BITS-1:0] letter_cnt;
  logic [COUNT_BITS-1:0] word_cnt;
  logic [COUNT_BITS-1:0] sentence_cnt;
  logic                  prev_letter;

  logic signed [NUM_W-1:0] num;
  logic                    neg;
  logic [DVD_W-1:0]        dvd;
  logic [DVS_W-1:0]        dvs;
  logic [DVS_W-1:0]        rem;
  logic [CNT_W-1:0]        div_cnt;

  logic                    is_letter;
  logic                    is_punct;
  logic signed [NUM_W-1:0] l_ext, s_ext, w_ext;
  logic signed [NUM_W-1:0] num_next;
  logic [MAG_W-1:0]        mag;
  logic [DVS_W-1:0]        den;
  logic [DVS_W:0]          rem_shift;
  logic                    q_bit;
  logic [DVD_W-1:0]        q;
  logic [rgi_pkg::GRADE_W-1:0]        grade_next;
  logic signed [rgi_pkg::FIELD_W-1:0] index_next;
  logic [CLIP_W-1:0]       l_wide, w_wide, s_wide;

  assign is_letter = (ch >= rgi_pkg::CH_UPPER_A && ch <= rgi_pkg::CH_UPPER_Z) ||
                     (ch >= rgi_pkg::CH_LOWER_A && ch <= rgi_pkg::CH_LOWER_Z);
  assign is_punct  = (ch == rgi_pkg::CH_PERIOD) || (ch == rgi_pkg::CH_EXCLAIM) ||
                     (ch == rgi_pkg::CH_QUESTION);

  // character counting, saturating
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      letter_cnt   <= '0;
      word_cnt     <= '0;
      sentence_cnt <= '0;
      prev_letter  <= 1'b0;
    end else if (cmd.count_en) begin
      if (is_letter && letter_cnt != '1) letter_cnt <= letter_cnt + 1'b1;
      if ((ch == rgi_pkg::CH_SPACE || last) && word_cnt != '1) word_cnt <= word_cnt + 1'b1;
      if (is_punct && prev_letter && sentence_cnt != '1) begin
        sentence_cnt <= sentence_cnt + 1'b1;
      end
      prev_letter <= is_letter;
    end
  end

  assign l_ext    = $signed({{(NUM_W - COUNT_BITS){1'b0}}, letter_cnt});
  assign s_ext    = $signed({{(NUM_W - COUNT_BITS){1'b0}}, sentence_cnt});
  assign w_ext    = $signed({{(NUM_W - COUNT_BITS){1'b0}}, word_cnt});
  assign num_next = l_ext * CoefL - s_ext * CoefS - w_ext * CoefW;

  assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  assign den = DVS_W'(word_cnt) * DenK;

  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign q_bit     = rem_shift >= {1'b0, dvs};

  // numerator, then rounding bias, then restoring division one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      num <= num_next;
    end
    if (cmd.load_mag) begin
      neg     <= num[NUM_W-1];
      dvd     <= DVD_W'({mag, 1'b0}) + DVD_W'(den);
      dvs     <= DVS_W'(word_cnt) * DvsK;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[DVD_W-2:0], q_bit};
      rem     <= q_bit ? DVS_W'(rem_shift - {1'b0, dvs}) : rem_shift[DVS_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign q = dvd;

  assign status.div_last = cmd.div_step && (div_cnt == DivLast);
  assign status.out_busy = out_valid && !out_ready;

  always_comb begin
    if (neg || q == '0) begin
      grade_next = '0;
    end else if (q >= DVD_W'(rgi_pkg::GRADE_HI)) begin
      grade_next = rgi_pkg::GRADE_W'(rgi_pkg::GRADE_HI);
    end else begin
      grade_next = q[rgi_pkg::GRADE_W-1:0];
    end
    if (neg) begin
      if (q > DVD_W'(32768)) index_next = 16'sh8000;
      else                   index_next = $signed(~q[15:0] + 16'd1);
    end else begin
      if (q > DVD_W'(32767)) index_next = 16'sh7FFF;
      else                   index_next = $signed(q[15:0]);
    end
  end

  assign l_wide = CLIP_W'(letter_cnt);
  assign w_wide = CLIP_W'(word_cnt);
  assign s_wide = CLIP_W'(sentence_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      grade     <= grade_next;
      index     <= index_next;
      letters   <= (l_wide > CLIP_W'(16'hFFFF)) ? 16'hFFFF : l_wide[15:0];
      words     <= (w_wide > CLIP_W'(16'hFFFF)) ? 16'hFFFF : w_wide[15:0];
      sentences <= (s_wide > CLIP_W'(16'hFFFF)) ? 16'hFFFF : s_wide[15:0];
    end
  end

endmodule
